// ===== rtl/core/alad_pkg.sv =====
// Package for the adaptive low-pass accelerometer filter with deadband.
// Holds the word types, register indexes, state codes and shared constants; no dependencies.
`default_nettype none
package alad_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LIM_W      = 15;
  localparam int ALPHA_W    = 16;
  localparam int ONE        = 4096;
  localparam int STEP_RECIP = 50;
  localparam int DIV3_MAGIC = 174763;
  localparam int DIV3_SHIFT = 19;
  localparam int MUL_W      = 19;
  localparam int PROD_W     = 38;
  localparam int SQRT_STEPS = 16;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smooth_x;
    logic signed [SAMPLE_W-1:0] smooth_y;
    logic signed [SAMPLE_W-1:0] smooth_z;
    logic signed [SAMPLE_W-1:0] limited_x;
    logic signed [SAMPLE_W-1:0] limited_y;
    logic signed [SAMPLE_W-1:0] limited_z;
  } out_word_t;

  typedef enum logic [2:0] {
    CFG_FILTER_K = 3'd0,
    CFG_ADAPT    = 3'd1,
    CFG_MIN_X    = 3'd2,
    CFG_MIN_Y    = 3'd3,
    CFG_MIN_Z    = 3'd4,
    CFG_MAX_X    = 3'd5,
    CFG_MAX_Y    = 3'd6,
    CFG_MAX_Z    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_RH_GO, ST_RH_WAIT, ST_RS_GO, ST_RS_WAIT,
    ST_SCALE, ST_ALPHA, ST_DIV, ST_ALOAD, ST_MIX, ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  // Deadband first, then magnitude limit.
  function automatic logic signed [SAMPLE_W-1:0] dead_limit(
      input logic signed [SAMPLE_W-1:0] v,
      input logic [LIM_W-1:0] lo,
      input logic [LIM_W-1:0] hi);
    logic signed [SAMPLE_W:0] vx, lox, hix;
    logic signed [SAMPLE_W-1:0] res;
    vx  = {v[SAMPLE_W-1], v};
    lox = {2'b00, lo};
    hix = {2'b00, hi};
    res = v;
    if (vx > 0) begin
      if (vx < lox) res = '0;
      else if (vx > hix) res = hix[SAMPLE_W-1:0];
    end else begin
      if (vx > -lox) res = '0;
      else if (vx < -hix) res = SAMPLE_W'(-hix);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/adaptive_lowpass_accel_deadband_top.sv =====
// Top level of the adaptive low-pass accelerometer filter with deadband and limit.
// Depends on alad_pkg and alad_isqrt.
//
// The block takes one three-axis sample word on the in_ channel and returns one
// word on the out_ channel: the new filtered vector and a copy of it in which
// each axis has passed its deadband and magnitude limit.
// A word is taken when in_valid is high and in_stall is low. The block raises
// in_stall while it works on a word, so one word is in flight at a time.
// In adaptive mode a word passes through the multiplier for the sums of squares,
// two passes of the shared 16-step square-root unit, the scale, alpha and
// divide-by-three products for the alpha factor and the per-axis mix. With
// adaptation off it goes straight to the mix. The next word is taken only
// once the previous result has moved to the output register. All
// multiplications go through a single 19x19 multiplier with a registered
// product. The result sits in an output register; a new word may be accepted
// while it waits. If the receiver stalls until the next result is ready, the
// block holds that result internally and keeps in_stall high until the
// output frees. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_wdata), to be used only while the block is idle; the block itself does
// not enforce this. Synchronous reset restores the register defaults and
// clears the filtered vector and all handshake state.
`default_nettype none
module adaptive_lowpass_accel_deadband_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  alad_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output alad_pkg::out_word_t  out_data,
  input  wire                  cfg_we,
  input  alad_pkg::cfg_idx_t   cfg_index,
  input  wire [15:0]           cfg_wdata
);
  import alad_pkg::*;

  // Configuration registers.
  logic [ALPHA_W-1:0] k_r;
  logic               adapt_r;
  logic [LIM_W-1:0]   min_r [3];
  logic [LIM_W-1:0]   max_r [3];

  // Filter state and the working copy of the sample.
  logic signed [SAMPLE_W-1:0] held_r [3];
  logic signed [SAMPLE_W-1:0] smp_r  [3];

  state_t               state_r, state_nxt;
  logic [2:0]           cnt_r;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [RAD_W-1:0]     sum_h_r, sum_s_r;
  logic [ROOT_W-1:0]    nh_r;
  logic signed [PROD_W-1:0] p_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  logic signed [MUL_W-1:0] ma, mb;
  logic                    sq_start, out_load;
  logic [RAD_W-1:0]        sq_rad;
  sqrt_stat_t              sq_stat;
  logic [ROOT_W-1:0]       sq_root;
  logic [1:0]              idx;
  logic signed [SAMPLE_W-1:0] opv;
  logic [ROOT_W-1:0]       diff;
  logic [12:0]             d;
  logic signed [SAMPLE_W:0] delta;
  logic                    in_acc;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  alad_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  // Axis select for the squaring and mixing passes.
  always_comb begin
    if (cnt_r < 3'd3)      idx = cnt_r[1:0];
    else if (cnt_r < 3'd6) idx = 2'(cnt_r - 3'd3);
    else                   idx = 2'd0;
  end

  assign opv   = (state_r == ST_SQ && cnt_r >= 3'd3) ? smp_r[idx] : held_r[idx];
  assign diff  = (nh_r > sq_root) ? (nh_r - sq_root) : (sq_root - nh_r);
  assign delta = {smp_r[idx][SAMPLE_W-1], smp_r[idx]} - {held_r[idx][SAMPLE_W-1], held_r[idx]};

  // The scaled magnitude change less one, clamped to the range zero to one.
  always_comb begin
    if (p_r <= PROD_W'(ONE))          d = '0;
    else if (p_r >= PROD_W'(2 * ONE)) d = 13'(ONE);
    else                              d = 13'(p_r - PROD_W'(ONE));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = adapt_r ? ST_SQ : ST_MIX;
      ST_SQ:      if (cnt_r == 3'd6) state_nxt = ST_RH_GO;
      ST_RH_GO:   state_nxt = ST_RH_WAIT;
      ST_RH_WAIT: if (sq_stat.done) state_nxt = ST_RS_GO;
      ST_RS_GO:   state_nxt = ST_RS_WAIT;
      ST_RS_WAIT: if (sq_stat.done) state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_ALPHA;
      ST_ALPHA:   state_nxt = ST_DIV;
      ST_DIV:     state_nxt = ST_ALOAD;
      ST_ALOAD:   state_nxt = ST_MIX;
      ST_MIX:     if (cnt_r == 3'd3) state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operands and unit controls.
  always_comb begin
    ma       = '0;
    mb       = '0;
    sq_start = 1'b0;
    sq_rad   = sum_h_r;
    out_load = 1'b0;
    case (state_r)
      ST_SQ: begin
        ma = MUL_W'(opv);
        mb = MUL_W'(opv);
      end
      ST_RH_GO: sq_start = 1'b1;
      ST_RS_GO: begin
        sq_start = 1'b1;
        sq_rad   = sum_s_r;
      end
      ST_SCALE: begin
        ma = MUL_W'({1'b0, diff});
        mb = MUL_W'(STEP_RECIP);
      end
      ST_ALPHA: begin
        ma = MUL_W'({1'b0, k_r});
        mb = MUL_W'({1'b0, d, 1'b0} + 15'(ONE));
      end
      ST_DIV: begin
        ma = MUL_W'({1'b0, p_r[29:12]});
        mb = MUL_W'(DIV3_MAGIC);
      end
      ST_MIX: begin
        ma = MUL_W'(delta);
        mb = MUL_W'({1'b0, alpha_r});
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= ALPHA_W'(6554);
      adapt_r <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        max_r[i] <= LIM_W'(4096);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_K: k_r      <= cfg_wdata[ALPHA_W-1:0];
        CFG_ADAPT:    adapt_r  <= cfg_wdata[0];
        CFG_MIN_X:    min_r[0] <= cfg_wdata[LIM_W-1:0];
        CFG_MIN_Y:    min_r[1] <= cfg_wdata[LIM_W-1:0];
        CFG_MIN_Z:    min_r[2] <= cfg_wdata[LIM_W-1:0];
        CFG_MAX_X:    max_r[0] <= cfg_wdata[LIM_W-1:0];
        CFG_MAX_Y:    max_r[1] <= cfg_wdata[LIM_W-1:0];
        CFG_MAX_Z:    max_r[2] <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          smp_r[0] <= in_data.sample_x;
          smp_r[1] <= in_data.sample_y;
          smp_r[2] <= in_data.sample_z;
          alpha_r  <= k_r;
          sum_h_r  <= '0;
          sum_s_r  <= '0;
        end
      end
      ST_SQ: begin
        if (cnt_r >= 3'd1 && cnt_r <= 3'd3) sum_h_r <= sum_h_r + p_r[RAD_W-1:0];
        if (cnt_r >= 3'd4) sum_s_r <= sum_s_r + p_r[RAD_W-1:0];
      end
      ST_RH_WAIT: if (sq_stat.done) nh_r <= sq_root;
      ST_ALOAD:   alpha_r <= p_r[DIV3_SHIFT+ALPHA_W-1:DIV3_SHIFT];
      default: ;
    endcase
  end

  // Filtered vector and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) held_r[i] <= '0;
      cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE:  cnt_r <= '0;
        ST_SQ:    cnt_r <= (cnt_r == 3'd6) ? 3'd0 : cnt_r + 3'd1;
        ST_ALOAD: cnt_r <= '0;
        ST_MIX: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r != 3'd0)
            held_r[2'(cnt_r - 3'd1)] <= SAMPLE_W'({held_r[2'(cnt_r - 3'd1)][SAMPLE_W-1],
                                                   held_r[2'(cnt_r - 3'd1)]} + p_r[32:16]);
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r.smooth_x  <= held_r[0];
      out_data_r.smooth_y  <= held_r[1];
      out_data_r.smooth_z  <= held_r[2];
      out_data_r.limited_x <= dead_limit(held_r[0], min_r[0], max_r[0]);
      out_data_r.limited_y <= dead_limit(held_r[1], min_r[1], max_r[1]);
      out_data_r.limited_z <= dead_limit(held_r[2], min_r[2], max_r[2]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted word always makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall) else $error("block not busy after accepting a word");

  // A new result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && out_valid_r && out_stall)) else $error("pending result overwritten");

  // The square-root unit only runs while the sequencer waits on it.
  a_sqrt_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.busy |-> (state_r == ST_RH_WAIT || state_r == ST_RS_WAIT))
    else $error("square-root unit busy outside its wait states");

endmodule
`default_nettype wire

// ===== rtl/core/alad_isqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
// Depends on alad_pkg for widths and the status struct.
`default_nettype none
module alad_isqrt (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [alad_pkg::RAD_W-1:0] radicand,
  output alad_pkg::sqrt_stat_t     stat,
  output logic [alad_pkg::ROOT_W-1:0] root
);
  import alad_pkg::*;

  logic [RAD_W-1:0] n_r, n_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [RAD_W-1:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    n_nxt    = n_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = radicand;
      root_nxt = '0;
      bit_nxt  = RAD_W'(1) << (RAD_W - 2);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt    = n_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r[ROOT_W-1:0];

endmodule
`default_nettype wire
